[hw/rtl/bounded_deque_bag_engine_core_defines.svh]
// Assertion macros used by the deque engine core RTL.
`ifndef BOUNDED_DEQUE_BAG_ENGINE_CORE_DEFINES_SVH
`define BOUNDED_DEQUE_BAG_ENGINE_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define BDBE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define BDBE_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[hw/rtl/bdbe_pkg.sv]
`timescale 1ns / 1ps

package bdbe_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_CONTAINS   = 3'd4,
    REQ_REMOVE     = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_FRONT,
    CELL_PUSH_BACK,
    CELL_POP_FRONT,
    CELL_REMOVE
  } cell_op_e;

  typedef struct packed {
    logic                   cmp_en;
    cell_op_e               op;
    logic [VALUE_WIDTH-1:0] operand;
    logic [CNT_W-1:0]       count;
  } cell_ctl_t;

endpackage

[hw/rtl/bdbe_cell.sv]
`timescale 1ns / 1ps

module bdbe_cell import bdbe_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cell_ctl_t              ctl_i,
  input  logic [IDX_W-1:0]       idx_i,
  input  logic [VALUE_WIDTH-1:0] left_val_i,
  input  logic [VALUE_WIDTH-1:0] right_val_i,
  input  logic                   hit_in_i,
  output logic [VALUE_WIDTH-1:0] val_o,
  output logic [VALUE_WIDTH-1:0] val_d_o,
  output logic                   hit_out_o
);

  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic                   match_q;
  logic                   occupied;

  assign occupied  = {1'b0, idx_i} < ctl_i.count;
  assign hit_out_o = hit_in_i | match_q;

  always_comb begin
    val_d = val_q;
    case (ctl_i.op)
      CELL_PUSH_FRONT: val_d = (idx_i == '0) ? ctl_i.operand : left_val_i;
      CELL_PUSH_BACK: begin
        if ({1'b0, idx_i} == ctl_i.count) val_d = ctl_i.operand;
      end
      CELL_POP_FRONT:  val_d = right_val_i;
      CELL_REMOVE: begin
        if (hit_out_o) val_d = right_val_i;
      end
      default:         val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctl_i.cmp_en) begin
      match_q <= occupied && (val_q == ctl_i.operand);
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o   = val_q;
  assign val_d_o = val_d;

endmodule

[hw/rtl/bounded_deque_bag_engine_core.sv]
`timescale 1ns / 1ps
// Channel  Handshake               Payload
// in       in_valid_i / in_stall_o  req_type_i, operand_value_i
// out      out_valid_o / out_stall_i status_o, found_o, front_value_o, back_value_o,
//                                   entry_count_o, is_empty_o
// A transaction is taken only while idle, then runs a compare step in every cell and an
// update step that shifts the row of cells and loads the result register.
// The result is registered after the compare and update states; input stays stalled until
// the update, so a new transaction is not taken before the last one is through.
// The update waits while a previous result is held by out_stall_i; input is taken
// whenever the engine is idle, even with a result still waiting.
// Reset clears the count and control; cell contents stay undefined, no clearing pass.

`include "bounded_deque_bag_engine_core_defines.svh"

module bounded_deque_bag_engine_core import bdbe_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [2:0]             req_type_i,
  input  logic [VALUE_WIDTH-1:0] operand_value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             status_o,
  output logic                   found_o,
  output logic [VALUE_WIDTH-1:0] front_value_o,
  output logic [VALUE_WIDTH-1:0] back_value_o,
  output logic [CNT_W-1:0]       entry_count_o,
  output logic                   is_empty_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPLY
  } state_e;

  state_e                 state_q;
  req_e                   req_q;
  logic [VALUE_WIDTH-1:0] operand_q;
  logic [CNT_W-1:0]       count_q, count_d, count_sub;
  logic                   out_valid_q, found_q, found_d;
  status_e                status_q, status_d;
  logic [VALUE_WIDTH-1:0] front_q, back_q, front_d, back_d;
  logic [CNT_W-1:0]       out_count_q;

  cell_ctl_t              ctl;
  cell_op_e               op_sel;
  logic                   in_accept, apply_go, full, empty;
  logic [IDX_W-1:0]       back_idx;

  logic [VALUE_WIDTH-1:0] val_q [DEPTH];
  logic [VALUE_WIDTH-1:0] val_d [DEPTH];
  logic [DEPTH:0]         hit;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign apply_go   = (state_q == ST_APPLY) && (!out_valid_q || !out_stall_i);
  assign full       = (count_q == CNT_W'(DEPTH));
  assign empty      = (count_q == '0);

  always_comb begin
    op_sel   = CELL_HOLD;
    status_d = STATUS_OK;
    found_d  = 1'b0;
    count_d  = count_q;
    case (req_q)
      REQ_PUSH_FRONT: begin
        if (full) status_d = STATUS_FULL;
        else begin
          op_sel  = CELL_PUSH_FRONT;
          count_d = count_q + 1'b1;
        end
      end
      REQ_PUSH_BACK: begin
        if (full) status_d = STATUS_FULL;
        else begin
          op_sel  = CELL_PUSH_BACK;
          count_d = count_q + 1'b1;
        end
      end
      REQ_POP_FRONT: begin
        if (empty) status_d = STATUS_EMPTY;
        else begin
          op_sel  = CELL_POP_FRONT;
          count_d = count_q - 1'b1;
        end
      end
      REQ_POP_BACK: begin
        if (empty) status_d = STATUS_EMPTY;
        else count_d = count_q - 1'b1;
      end
      REQ_CONTAINS: found_d = hit[DEPTH];
      REQ_REMOVE: begin
        found_d = hit[DEPTH];
        op_sel  = CELL_REMOVE;
        if (hit[DEPTH]) count_d = count_q - 1'b1;
      end
      default: op_sel = CELL_HOLD;
    endcase
  end

  always_comb begin
    ctl.cmp_en  = (state_q == ST_CMP);
    ctl.op      = apply_go ? op_sel : CELL_HOLD;
    ctl.operand = operand_q;
    ctl.count   = count_q;
  end

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_val, right_val;
    if (i == 0) begin : g_first
      assign left_val = operand_q;
    end else begin : g_mid
      assign left_val = val_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_inner
      assign right_val = val_q[i+1];
    end
    bdbe_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .idx_i       (IDX_W'(i)),
      .left_val_i  (left_val),
      .right_val_i (right_val),
      .hit_in_i    (hit[i]),
      .val_o       (val_q[i]),
      .val_d_o     (val_d[i]),
      .hit_out_o   (hit[i+1])
    );
  end

  assign count_sub = count_d - 1'b1;
  assign back_idx  = count_sub[IDX_W-1:0];
  assign front_d   = (count_d == '0) ? '0 : val_d[0];
  assign back_d    = (count_d == '0) ? '0 : val_d[back_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      req_q       <= REQ_PUSH_FRONT;
      operand_q   <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= STATUS_OK;
      found_q     <= 1'b0;
      front_q     <= '0;
      back_q      <= '0;
      out_count_q <= '0;
    end else begin
      if (apply_go) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            req_q     <= req_e'(req_type_i);
            operand_q <= operand_value_i;
            state_q   <= ST_CMP;
          end
        end
        ST_CMP: state_q <= ST_APPLY;
        ST_APPLY: begin
          if (apply_go) begin
            count_q     <= count_d;
            status_q    <= status_d;
            found_q     <= found_d;
            front_q     <= front_d;
            back_q      <= back_d;
            out_count_q <= count_d;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_o       = found_q;
  assign front_value_o = front_q;
  assign back_value_o  = back_q;
  assign entry_count_o = out_count_q;
  assign is_empty_o    = (out_count_q == '0);

  `BDBE_NEVER(a_count_bound, count_q > CNT_W'(DEPTH), "entry count above depth")
  `BDBE_ASSERT(a_accept_cmp, in_accept |=> (state_q == ST_CMP), "accept not followed by compare")
  `BDBE_NEVER(a_found_status, out_valid_o && found_o && (status_o != STATUS_OK),
              "found flagged with error status")
  `BDBE_ASSERT(a_count_step, apply_go |=> ((count_q == $past(count_q)) ||
               (count_q == $past(count_q) + 1'b1) || (count_q == $past(count_q) - 1'b1)),
               "entry count moved by more than one")

endmodule

[tb/deque_checker.sv]
`timescale 1ns / 1ps

module deque_checker import bdbe_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic [2:0]             req_type_i,
  input  logic [VALUE_WIDTH-1:0] operand_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic [1:0]             status_i,
  input  logic                   found_i,
  input  logic [VALUE_WIDTH-1:0] front_i,
  input  logic [VALUE_WIDTH-1:0] back_i,
  input  logic [CNT_W-1:0]       count_i,
  input  logic                   empty_i,
  output int                     mismatches_o,
  output int                     pending_o
);

  typedef struct packed {
    logic [1:0]             status;
    logic                   found;
    logic [VALUE_WIDTH-1:0] front;
    logic [VALUE_WIDTH-1:0] back;
    logic [CNT_W-1:0]       count;
    logic                   empty;
  } deque_view_t;

  logic [VALUE_WIDTH-1:0] contents[$];
  deque_view_t            views_due[$];
  int                     mismatch_cnt;

  task automatic apply_request(input logic [2:0] req, input logic [VALUE_WIDTH-1:0] val);
    deque_view_t view;
    int          hit;
    view = '0;
    view.status = STATUS_OK;
    hit = -1;
    case (req)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (contents.size() >= DEPTH) begin
          view.status = STATUS_FULL;
        end else if (req == REQ_PUSH_FRONT) begin
          contents.push_front(val);
        end else begin
          contents.push_back(val);
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (contents.size() == 0) begin
          view.status = STATUS_EMPTY;
        end else if (req == REQ_POP_FRONT) begin
          void'(contents.pop_front());
        end else begin
          void'(contents.pop_back());
        end
      end
      REQ_CONTAINS, REQ_REMOVE: begin
        foreach (contents[i]) begin
          if (hit < 0 && contents[i] == val) hit = i;
        end
        view.found = (hit >= 0);
        if (req == REQ_REMOVE && hit >= 0) contents.delete(hit);
      end
      default: ;
    endcase
    view.count = CNT_W'(contents.size());
    view.empty = (contents.size() == 0);
    if (contents.size() != 0) begin
      view.front = contents[0];
      view.back  = contents[contents.size() - 1];
    end
    views_due.push_back(view);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    deque_view_t want;
    deque_view_t got;
    if (!rst_ni) begin
      contents.delete();
      views_due.delete();
      mismatch_cnt = 0;
      mismatches_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{status_i, found_i, front_i, back_i, count_i, empty_i};
        if (views_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%t: unexpected transaction st=%0d fd=%0b fr=%h bk=%h n=%0d e=%0b",
                     $realtime, got.status, got.found, got.front, got.back, got.count,
                     got.empty);
        end else begin
          want = views_due.pop_front();
          if (want.status !== got.status || want.found !== got.found ||
              want.front !== got.front || want.back !== got.back ||
              want.count !== got.count || want.empty !== got.empty) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("%t: mismatch want st=%0d fd=%0b fr=%h bk=%h n=%0d e=%0b",
                       $realtime, want.status, want.found, want.front, want.back,
                       want.count, want.empty);
              $display("%t:            got st=%0d fd=%0b fr=%h bk=%h n=%0d e=%0b",
                       $realtime, got.status, got.found, got.front, got.back,
                       got.count, got.empty);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) apply_request(req_type_i, operand_i);
      mismatches_o <= mismatch_cnt;
      pending_o <= views_due.size();
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb import bdbe_pkg::*; ();

  localparam logic [2:0] REQ_UNUSED_A = 3'd6;
  localparam logic [2:0] REQ_UNUSED_B = 3'd7;
  localparam int         RANDOM_REQS  = 1000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [2:0]             req_type_i;
  logic [VALUE_WIDTH-1:0] operand_value_i;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [1:0]             status_o;
  logic                   found_o;
  logic [VALUE_WIDTH-1:0] front_value_o;
  logic [VALUE_WIDTH-1:0] back_value_o;
  logic [CNT_W-1:0]       entry_count_o;
  logic                   is_empty_o;
  int                     mismatches;
  int                     pending;
  int                     idle_pct = 0;
  int                     stall_pct = 0;

  bounded_deque_bag_engine_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .operand_value_i(operand_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .found_o        (found_o),
    .front_value_o  (front_value_o),
    .back_value_o   (back_value_o),
    .entry_count_o  (entry_count_o),
    .is_empty_o     (is_empty_o)
  );

  deque_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .req_type_i  (req_type_i),
    .operand_i   (operand_value_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status_o),
    .found_i     (found_o),
    .front_i     (front_value_o),
    .back_i      (back_value_o),
    .count_i     (entry_count_o),
    .empty_i     (is_empty_o),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

  task automatic send(input logic [2:0] req, input logic [VALUE_WIDTH-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= req;
    operand_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    case ($urandom_range(11))
      0, 1, 2: return $urandom;
      3:       return 32'h0000_0000;
      4:       return 32'hffff_ffff;
      5:       return 32'h7fff_ffff;
      6:       return 32'h8000_0000;
      7:       return 32'h5555_5555;
      8:       return 32'haaaa_aaaa;
      9:       return 32'h0000_0001;
      default: return 32'h0000_002a;
    endcase
  endfunction

  initial begin : stimulus
    int               n;
    int               roll;
    int               push_w;
    int               pop_w;
    logic [2:0]       req;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    req_type_i      = REQ_PUSH_FRONT;
    operand_value_i = '0;
    push_w          = 60;
    pop_w           = 15;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    send(REQ_POP_FRONT, 32'h1234_5678);
    send(REQ_POP_BACK, 32'hffff_ffff);
    send(REQ_CONTAINS, 32'h0000_0000);
    send(REQ_REMOVE, 32'h0000_0000);
    send(REQ_UNUSED_A, 32'hffff_ffff);
    send(REQ_UNUSED_B, 32'h0000_0000);
    send(REQ_PUSH_BACK, 32'h7fff_ffff);
    send(REQ_PUSH_FRONT, 32'h8000_0000);
    send(REQ_PUSH_BACK, 32'h0000_0000);
    send(REQ_PUSH_FRONT, 32'hffff_ffff);
    send(REQ_PUSH_BACK, 32'h0000_0005);
    send(REQ_PUSH_BACK, 32'h0000_0009);
    send(REQ_PUSH_BACK, 32'h0000_0005);
    send(REQ_CONTAINS, 32'h8000_0000);
    send(REQ_CONTAINS, 32'h0012_3456);
    send(REQ_REMOVE, 32'h0000_0005);
    send(REQ_REMOVE, 32'h0000_0063);
    send(REQ_REMOVE, 32'hffff_ffff);
    send(REQ_REMOVE, 32'h0000_0005);
    send(REQ_POP_FRONT, 32'h0000_0000);
    send(REQ_POP_BACK, 32'h0000_0000);
    send(REQ_UNUSED_A, 32'h0000_0000);
    drain();

    for (n = 0; n < RANDOM_REQS; n++) begin
      case ((n / 64) % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 64; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 64; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      if (n % 48 == 0) begin
        case ($urandom_range(2))
          0:       push_w = 15;
          1:       push_w = 40;
          default: push_w = 60;
        endcase
        pop_w = 75 - push_w;
      end
      if (n == RANDOM_REQS / 2) drain();
      roll = $urandom_range(99);
      if (roll < 3)
        req = $urandom_range(1) ? REQ_UNUSED_A : REQ_UNUSED_B;
      else if ((roll - 3) * 100 < push_w * 97)
        req = $urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
      else if ((roll - 3) * 100 < (push_w + pop_w) * 97)
        req = $urandom_range(1) ? REQ_POP_FRONT : REQ_POP_BACK;
      else
        req = $urandom_range(1) ? REQ_CONTAINS : REQ_REMOVE;
      send(req, pick_value());
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/bdbe_pkg.sv
hw/rtl/bdbe_cell.sv
hw/rtl/bounded_deque_bag_engine_core.sv
tb/deque_checker.sv
tb/tb.sv
